>>> src/gsme_pkg.sv
// ----------------------------------------------------------------------------
// gsme_pkg
// Shared types and constants of the segmentation merge engine.
// ----------------------------------------------------------------------------
`default_nettype none
package gsme_pkg;
  localparam int unsigned WeightWidth = 16;
  localparam int unsigned KWidth      = 24;
  localparam int unsigned SizeWidth   = 17;
  localparam int unsigned RankWidth   = 5;
  localparam int unsigned VertWidth   = 16;
  // one memory row per vertex index; weight and k share the fraction format
  localparam int unsigned VertexCount    = 65536;
  localparam int unsigned WeightFracBits = 8;
  localparam logic [RankWidth-1:0] RankMax = 5'd31;
  localparam logic [KWidth-1:0]    KReset  = 24'd76800;

  localparam logic OpMerge = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef enum logic [4:0] {
    StIdle,
    StClear,
    StWalkRd,
    StWalkChk,
    StCompRd,
    StCompChk,
    StSwitch,
    StRootRdA,
    StRootRdB,
    StRootLat,
    StDivA,
    StDivB,
    StDecide,
    StWrite,
    StOutRd,
    StOutLat,
    StOut
  } state_e;
endpackage
`default_nettype wire

>>> src/graph_segmentation_merge_engine_unit.sv
// Flow: each walked end takes a root walk, then path compression; then come the
//   root reads, a serial division for an edge across components, and the output.
// Throughput: one item at a time; the next item is taken while a result waits.
//   After reset a clearing pass over every row initializes the memories.
// ----------------------------------------------------------------------------
// graph_segmentation_merge_engine_unit
// Union-find merge engine with per-vertex state held in synchronous memories.
// ----------------------------------------------------------------------------
`default_nettype none
module graph_segmentation_merge_engine_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [gsme_pkg::KWidth-1:0]    cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           opcode_i,
  input  wire logic [gsme_pkg::VertWidth-1:0] vertex_a_i,
  input  wire logic [gsme_pkg::VertWidth-1:0] vertex_b_i,
  input  wire logic [gsme_pkg::WeightWidth-1:0] edge_weight_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                merged_o,
  output logic [gsme_pkg::VertWidth-1:0]      root_o,
  output logic [gsme_pkg::SizeWidth-1:0]      component_size_o,
  output logic [gsme_pkg::WeightWidth-1:0]    internal_weight_o
);
  import gsme_pkg::*;

  localparam int unsigned AW = $clog2(VertexCount);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned TauW = KWidth;

  // memories: parent, rank, size, internal weight
  logic [AW-1:0]          parent_mem [VertexCount];
  logic [RankWidth-1:0]   rank_mem   [VertexCount];
  logic [SizeWidth-1:0]   size_mem   [VertexCount];
  logic [WeightWidth-1:0] wt_mem     [VertexCount];

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] par_wdata;
  logic          aux_we;
  logic [AW-1:0] aux_waddr;
  logic [RankWidth-1:0]   rank_wdata;
  logic [SizeWidth-1:0]   size_wdata;
  logic [WeightWidth-1:0] wt_wdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] par_rdata;
  logic [RankWidth-1:0]   rank_rdata;
  logic [SizeWidth-1:0]   size_rdata;
  logic [WeightWidth-1:0] wt_rdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      parent_mem[mem_waddr] <= par_wdata;
    end
    par_rdata <= parent_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (aux_we) begin
      rank_mem[aux_waddr] <= rank_wdata;
      size_mem[aux_waddr] <= size_wdata;
      wt_mem[aux_waddr]   <= wt_wdata;
    end
    rank_rdata <= rank_mem[raddr];
    size_rdata <= size_mem[raddr];
    wt_rdata   <= wt_mem[raddr];
  end

  state_e state_q, state_d;
  logic [KWidth-1:0] k_q;
  logic [CW-1:0] clr_q, clr_d;
  logic op_q, op_d;
  logic [AW-1:0] va_q, va_d, vb_q, vb_d;
  logic [WeightWidth-1:0] w_q, w_d;
  logic side_q, side_d;             // 0 = walking vertex a, 1 = vertex b
  logic [AW-1:0] cur_q, cur_d;      // current vertex of walk
  logic [AW-1:0] start_q, start_d;
  logic [AW-1:0] ra_q, ra_d, rb_q, rb_d;
  logic [RankWidth-1:0] rka_q, rka_d, rkb_q, rkb_d;
  logic [SizeWidth-1:0] sza_q, sza_d, szb_q, szb_d;
  logic [WeightWidth-1:0] wta_q, wta_d, wtb_q, wtb_d;
  logic [TauW-1:0] quo_q, quo_d, rem_q, rem_d;
  logic [TauW-1:0] taua_q, taua_d;
  logic [$clog2(TauW+1)-1:0] dcnt_q, dcnt_d;
  logic merged_q, merged_d;
  logic out_valid_q, out_valid_d;
  logic omg_q, omg_d;
  logic [VertWidth-1:0] root_q, root_d;
  logic [SizeWidth-1:0] osz_q, osz_d;
  logic [WeightWidth-1:0] owt_q, owt_d;

  // restoring division step, one quotient bit per cycle
  logic [SizeWidth-1:0] div_n;
  logic [TauW:0] rem_sh;
  logic [TauW:0] rem_sub;
  logic [31:0] tha, thb, mint;
  logic a_keeps;
  logic [WeightWidth-1:0] mx0, mx1;
  logic [SizeWidth-1:0] sz_sum;

  assign div_n   = (state_q == StDivA) ? sza_q : szb_q;
  assign rem_sh  = {rem_q, quo_q[TauW-1]};
  assign rem_sub = rem_sh - {{(TauW+1-SizeWidth){1'b0}}, div_n};
  assign tha  = 32'(wta_q) + 32'(taua_q);
  assign thb  = 32'(wtb_q) + 32'(quo_q);
  assign mint = (tha < thb) ? tha : thb;
  assign a_keeps = !(rka_q < rkb_q);
  assign mx0 = (wta_q > wtb_q) ? wta_q : wtb_q;
  assign mx1 = (w_q > mx0) ? w_q : mx0;
  assign sz_sum = sza_q + szb_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear:   state_d = (clr_q == CW'(VertexCount - 1)) ? StIdle : StClear;
      StIdle:    state_d = in_valid_i ? StWalkRd : StIdle;
      StWalkRd:  state_d = StWalkChk;
      StWalkChk: state_d = (par_rdata == cur_q) ? StCompRd : StWalkRd;
      StCompRd:  state_d = StCompChk;
      StCompChk: state_d = (par_rdata == cur_q || cur_q == (side_q ? rb_q : ra_q))
                           ? StSwitch : StCompRd;
      StSwitch:  state_d = (side_q || op_q == OpQuery) ? StRootRdA : StWalkRd;
      StRootRdA: state_d = StRootRdB;
      StRootRdB: state_d = StRootLat;
      StRootLat: state_d = (op_q == OpQuery || ra_q == rb_q) ? StOutRd : StDivA;
      StDivA:    state_d = (dcnt_q == '0) ? StDivB : StDivA;
      StDivB:    state_d = (dcnt_q == '0) ? StDecide : StDivB;
      StDecide:  state_d = (32'(w_q) < mint) ? StWrite : StOutRd;
      StWrite:   state_d = StOutRd;
      StOutRd:   state_d = StOutLat;
      StOutLat:  state_d = StOut;
      StOut:     state_d = (out_valid_q && out_stall_i) ? StOut : StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_comb begin
    clr_d = clr_q; op_d = op_q; va_d = va_q; vb_d = vb_q; w_d = w_q;
    side_d = side_q; cur_d = cur_q; start_d = start_q;
    ra_d = ra_q; rb_d = rb_q; rka_d = rka_q; rkb_d = rkb_q;
    sza_d = sza_q; szb_d = szb_q; wta_d = wta_q; wtb_d = wtb_q;
    quo_d = quo_q; rem_d = rem_q; taua_d = taua_q; dcnt_d = dcnt_q;
    merged_d = merged_q;
    out_valid_d = out_valid_q && out_stall_i;
    omg_d = omg_q; root_d = root_q; osz_d = osz_q; owt_d = owt_q;
    mem_we = 1'b0; aux_we = 1'b0; mem_waddr = cur_q; par_wdata = ra_q;
    aux_waddr = cur_q;
    rank_wdata = '0; size_wdata = SizeWidth'(1); wt_wdata = '0;
    raddr = cur_q;
    in_stall_o = 1'b1;
    case (state_q)
      StClear: begin
        mem_we = 1'b1; aux_we = 1'b1;
        mem_waddr = clr_q[AW-1:0]; par_wdata = clr_q[AW-1:0];
        aux_waddr = clr_q[AW-1:0];
        clr_d = clr_q + 1'b1;
      end
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_d = opcode_i;
          va_d = vertex_a_i;
          vb_d = vertex_b_i;
          w_d = edge_weight_i;
          side_d = 1'b0; merged_d = 1'b0;
          cur_d = vertex_a_i;
          start_d = vertex_a_i;
        end
      end
      StWalkRd: raddr = cur_q;
      StWalkChk: begin
        // follow the parent link until a self loop marks the root
        if (par_rdata == cur_q) begin
          if (side_q) rb_d = cur_q; else ra_d = cur_q;
          cur_d = start_q;
        end else begin
          cur_d = par_rdata;
        end
      end
      StCompRd: raddr = cur_q;
      StCompChk: begin
        // point each walked vertex at the root
        if (!(par_rdata == cur_q || cur_q == (side_q ? rb_q : ra_q))) begin
          mem_we = 1'b1; mem_waddr = cur_q;
          par_wdata = side_q ? rb_q : ra_q;
          cur_d = par_rdata;
        end
      end
      StSwitch: begin
        side_d = 1'b1; cur_d = vb_q; start_d = vb_q;
        if (op_q == OpQuery) rb_d = ra_q;
      end
      StRootRdA: raddr = ra_q;
      StRootRdB: begin
        raddr = rb_q;
        rka_d = rank_rdata; sza_d = size_rdata; wta_d = wt_rdata;
      end
      StRootLat: begin
        rkb_d = rank_rdata; szb_d = size_rdata; wtb_d = wt_rdata;
        quo_d = k_q; rem_d = '0; dcnt_d = ($bits(dcnt_q))'(TauW - 1);
      end
      StDivA, StDivB: begin
        if (rem_sub[TauW]) begin
          rem_d = rem_sh[TauW-1:0];
          quo_d = {quo_q[TauW-2:0], 1'b0};
        end else begin
          rem_d = rem_sub[TauW-1:0];
          quo_d = {quo_q[TauW-2:0], 1'b1};
        end
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == '0 && state_q == StDivA) begin
          taua_d = rem_sub[TauW] ? {quo_q[TauW-2:0], 1'b0} : {quo_q[TauW-2:0], 1'b1};
          quo_d = k_q; rem_d = '0; dcnt_d = ($bits(dcnt_q))'(TauW - 1);
        end
      end
      StDecide: ;
      StWrite: begin
        // link the loser under the winner and update the winner's row
        merged_d = 1'b1;
        mem_we = 1'b1; aux_we = 1'b1;
        mem_waddr = a_keeps ? rb_q : ra_q;
        par_wdata = a_keeps ? ra_q : rb_q;
        aux_waddr = a_keeps ? ra_q : rb_q;
        rank_wdata = (a_keeps && rka_q == rkb_q && rka_q < RankMax)
                     ? rka_q + RankWidth'(1) : (a_keeps ? rka_q : rkb_q);
        size_wdata = sz_sum;
        wt_wdata = mx1;
        if (!a_keeps) ra_d = rb_q;
      end
      StOutRd: raddr = ra_q;
      StOutLat: raddr = ra_q;
      StOut: begin
        raddr = ra_q;
        // hold until the previous result transfer is taken
        if (!(out_valid_q && out_stall_i)) begin
          out_valid_d = 1'b1;
          omg_d = merged_q;
          root_d = VertWidth'(ra_q);
          osz_d = size_rdata; owt_d = wt_rdata;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      k_q <= KReset;
      clr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) k_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; va_q <= va_d; vb_q <= vb_d; w_q <= w_d;
    side_q <= side_d; cur_q <= cur_d; start_q <= start_d;
    ra_q <= ra_d; rb_q <= rb_d; rka_q <= rka_d; rkb_q <= rkb_d;
    sza_q <= sza_d; szb_q <= szb_d; wta_q <= wta_d; wtb_q <= wtb_d;
    quo_q <= quo_d; rem_q <= rem_d; taua_q <= taua_d; dcnt_q <= dcnt_d;
    merged_q <= merged_d; omg_q <= omg_d;
    root_q <= root_d; osz_q <= osz_d; owt_q <= owt_d;
  end

  assign out_valid_o       = out_valid_q;
  assign merged_o          = omg_q;
  assign root_o            = root_q;
  assign component_size_o  = osz_q;
  assign internal_weight_o = owt_q;
endmodule
`default_nettype wire

>>> test/gsme_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsme_checker
// Watches the edge and result channels of the merge engine, runs a union-find
// shadow model on every input transfer and compares each result transfer.
// ----------------------------------------------------------------------------
module gsme_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [gsme_pkg::KWidth-1:0]      cfg_wdata_i,
  input  wire logic                             in_valid_i,
  input  wire logic                             in_stall_i,
  input  wire logic                             opcode_i,
  input  wire logic [gsme_pkg::VertWidth-1:0]   vertex_a_i,
  input  wire logic [gsme_pkg::VertWidth-1:0]   vertex_b_i,
  input  wire logic [gsme_pkg::WeightWidth-1:0] edge_weight_i,
  input  wire logic                             out_valid_i,
  input  wire logic                             out_stall_i,
  input  wire logic                             merged_i,
  input  wire logic [gsme_pkg::VertWidth-1:0]   root_i,
  input  wire logic [gsme_pkg::SizeWidth-1:0]   component_size_i,
  input  wire logic [gsme_pkg::WeightWidth-1:0] internal_weight_i,
  output int                                    fail_count_o,
  output int                                    pending_o
);
  import gsme_pkg::*;

  typedef struct packed {
    logic                   merged;
    logic [VertWidth-1:0]   root;
    logic [SizeWidth-1:0]   size;
    logic [WeightWidth-1:0] weight;
  } seg_result_t;

  logic [VertWidth-1:0]   parent_q [65536];
  logic [RankWidth-1:0]   rank_q   [65536];
  logic [SizeWidth-1:0]   count_q  [65536];
  logic [WeightWidth-1:0] inner_q  [65536];
  logic [KWidth-1:0]      k_q;
  seg_result_t            expected_results [$];

  function automatic logic [VertWidth-1:0] find_root(logic [VertWidth-1:0] v);
    logic [VertWidth-1:0] r;
    logic [VertWidth-1:0] nxt;
    r = v;
    while (parent_q[r] != r) r = parent_q[r];
    // compress the walked path
    while (v != r) begin
      nxt = parent_q[v];
      parent_q[v] = r;
      v = nxt;
    end
    return r;
  endfunction

  function automatic logic [31:0] merge_limit(logic [VertWidth-1:0] r);
    logic [31:0] tau;
    tau = (count_q[r] != 0) ? 32'(k_q) / 32'(count_q[r]) : 32'(k_q);
    return 32'(inner_q[r]) + tau;
  endfunction

  function automatic seg_result_t predict_segment(logic op, logic [VertWidth-1:0] a,
      logic [VertWidth-1:0] b, logic [WeightWidth-1:0] w);
    seg_result_t res;
    logic [VertWidth-1:0] ra, rb, keep, lose;
    logic [31:0] ta, tb, mint;
    logic [WeightWidth-1:0] mx;
    res = '0;
    ra = find_root(a);
    if (op == OpMerge) begin
      rb = find_root(b);
      if (ra != rb) begin
        ta = merge_limit(ra);
        tb = merge_limit(rb);
        mint = (ta < tb) ? ta : tb;
        if (32'(w) < mint) begin
          if (rank_q[ra] < rank_q[rb]) begin
            keep = rb;
            lose = ra;
          end else begin
            keep = ra;
            lose = rb;
            if (rank_q[ra] == rank_q[rb] && rank_q[ra] < RankMax) rank_q[ra]++;
          end
          parent_q[lose] = keep;
          count_q[keep] = count_q[keep] + count_q[lose];
          mx = inner_q[keep];
          if (inner_q[lose] > mx) mx = inner_q[lose];
          if (w > mx) mx = w;
          inner_q[keep] = mx;
          res.merged = 1'b1;
          ra = keep;
        end
      end
    end
    res.root = ra;
    res.size = count_q[ra];
    res.weight = inner_q[ra];
    return res;
  endfunction

  assign pending_o = expected_results.size();

  initial begin
    fail_count_o = 0;
    k_q = KReset;
    for (int i = 0; i < 65536; i++) begin
      parent_q[i] = VertWidth'(i);
      rank_q[i] = '0;
      count_q[i] = 1;
      inner_q[i] = '0;
    end
  end

  always @(posedge clk_i) begin
    seg_result_t got;
    seg_result_t exp_r;
    seg_result_t pred;
    if (rst_ni) begin
      if (cfg_we_i) k_q <= cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        got = '{merged_i, root_i, component_size_i, internal_weight_i};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transfer %p", $realtime, got);
          fail_count_o++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, exp_r, got);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pred = predict_segment(opcode_i, vertex_a_i, vertex_b_i, edge_weight_i);
        expected_results = {expected_results, pred};
      end
    end
  end
endmodule

>>> test/tb_graph_segmentation_merge_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_graph_segmentation_merge_engine_unit
// Drives edge and query transfers with random idling on both channels across
// several k settings; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_graph_segmentation_merge_engine_unit;
  import gsme_pkg::*;

  localparam int WatchdogLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [KWidth-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic opcode_i = 1'b0;
  logic [VertWidth-1:0] vertex_a_i = '0;
  logic [VertWidth-1:0] vertex_b_i = '0;
  logic [WeightWidth-1:0] edge_weight_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic merged_o;
  logic [VertWidth-1:0] root_o;
  logic [SizeWidth-1:0] component_size_o;
  logic [WeightWidth-1:0] internal_weight_o;
  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit quiet_phase = 1'b0;
  bit hold_off = 1'b0;
  logic [WeightWidth-1:0] ramp_w = '0;

  always #1 clk_i = ~clk_i;

  graph_segmentation_merge_engine_unit u_top (.*);

  gsme_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_i(in_stall_o),
    .opcode_i, .vertex_a_i, .vertex_b_i, .edge_weight_i, .out_valid_i(out_valid_o),
    .out_stall_i, .merged_i(merged_o), .root_i(root_o), .component_size_i(component_size_o),
    .internal_weight_i(internal_weight_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog: count cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stall bursts, plus one long hold-off
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (2000) @(negedge clk_i);
        hold_off = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        n = $urandom_range(1, 18);
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_item(logic op, logic [VertWidth-1:0] a, logic [VertWidth-1:0] b,
                           logic [WeightWidth-1:0] w);
    int gap;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    vertex_a_i <= a;
    vertex_b_i <= b;
    edge_weight_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain_engine();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_k(logic [KWidth-1:0] k);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= k;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly ascending edges over a small vertex pool so that trees grow deep
  task automatic random_phase(int count, int span);
    logic [VertWidth-1:0] a, b;
    logic [WeightWidth-1:0] w;
    for (int i = 0; i < count; i++) begin
      a = VertWidth'($urandom_range(0, span));
      b = VertWidth'($urandom_range(0, span));
      if ($urandom_range(0, 9) == 0) a = VertWidth'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        w = WeightWidth'($urandom);
      end else begin
        ramp_w = ramp_w + WeightWidth'($urandom_range(0, 3));
        w = ramp_w;
      end
      send_item($urandom_range(0, 4) == 0 ? OpQuery : OpMerge, a, b, w);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, queries, same component, ties
    send_item(OpQuery, 16'd0, 16'd0, 16'd0);
    send_item(OpMerge, 16'd0, 16'd1, 16'd0);
    send_item(OpMerge, 16'd1, 16'd0, 16'd5);
    send_item(OpMerge, 16'hFFFF, 16'hFFFE, 16'hFFFF);
    send_item(OpMerge, 16'hFFFF, 16'hFFFE, 16'd100);
    send_item(OpMerge, 16'd2, 16'd3, 16'd200);
    send_item(OpMerge, 16'd0, 16'd2, 16'd300);
    send_item(OpMerge, 16'd3, 16'd1, 16'd400);
    send_item(OpQuery, 16'd3, 16'hFFFF, 16'hFFFF);
    send_item(OpQuery, 16'hFFFE, 16'h5555, 16'hAAAA);
    send_item(OpMerge, 16'hAAAA, 16'h5555, 16'h5555);
    send_item(OpMerge, 16'd4, 16'd4, 16'd0);
    drain_engine();
    write_k(24'hFFFFFF);
    send_item(OpMerge, 16'd0, 16'hFFFF, 16'hFFFE);
    send_item(OpMerge, 16'd10, 16'd11, 16'hFFFF);
    send_item(OpQuery, 16'd11, 16'd0, 16'd0);
    drain_engine();
    write_k(24'd0);
    send_item(OpMerge, 16'd20, 16'd21, 16'd0);
    send_item(OpMerge, 16'd0, 16'd20, 16'd0);
    drain_engine();
    write_k(KReset);
    random_phase(250, 300);
    // fill the engine against a held-off receiver
    hold_off = 1'b1;
    random_phase(50, 300);
    drain_engine();
    write_k(24'd1 << 14);
    ramp_w = '0;
    random_phase(250, 63);
    drain_engine();
    write_k(24'd2560);
    quiet_phase = 1'b1;
    random_phase(250, 2000);
    drain_engine();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

>>> files.f
src/gsme_pkg.sv
src/graph_segmentation_merge_engine_unit.sv
test/gsme_checker.sv
test/tb_graph_segmentation_merge_engine_unit.sv
